@@ rtl/core/rgbled_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbled_pkg
// Types and constants shared by the LED strip serial driver files.
// ----------------------------------------------------------------------------
package rgbled_pkg;

	localparam int FUNC_W     = 3;
	localparam int IDX_W      = 10;
	localparam int COLOR_W    = 8;
	localparam int TIME_W     = 8;
	localparam int GAP_W      = 16;
	localparam int LED_CNT_W  = 11;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// command codes
	localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SET   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_FILL  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SEND  = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_GAP  = 3'd5;

	// register reset values
	localparam logic [TIME_W-1:0] RST_ZERO_HIGH = 8'd4;
	localparam logic [TIME_W-1:0] RST_ZERO_LOW  = 8'd9;
	localparam logic [TIME_W-1:0] RST_ONE_HIGH  = 8'd8;
	localparam logic [TIME_W-1:0] RST_ONE_LOW   = 8'd5;
	localparam logic [GAP_W-1:0]  RST_GAP       = 16'd800;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [IDX_W-1:0]   pixel_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} cmd_t;

	typedef struct packed {
		logic                line_level;
		logic                busy_res;
		logic [STATUS_W-1:0] status;
	} res_t;

	// timing registers, held at their effective (nonzero) values
	typedef struct packed {
		logic [TIME_W-1:0] zero_high;
		logic [TIME_W-1:0] zero_low;
		logic [TIME_W-1:0] one_high;
		logic [TIME_W-1:0] one_low;
		logic [GAP_W-1:0]  gap;
	} timing_t;

	typedef struct packed {
		logic tick;
		logic start;
	} wave_cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_GAP
	} phase_t;

	typedef enum logic [2:0] {
		SQ_CLEAR,
		SQ_READY,
		SQ_FILL,
		SQ_LOAD,
		SQ_START
	} seq_state_t;

endpackage

@@ rtl/core/rgb_led_strip_serial_driver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_strip_serial_driver
// Pixel store and serial frame driver for a strip of smart RGB pixels.
//
//   channel  dir  handshake                  payload
//   cmd      in   cmd_valid / cmd_stall      cmd   (func, index, color)
//   res      out  res_valid / res_stall      res   (line, busy, status)
//   cfg      in   cfg_write                  cfg_index, cfg_data
//
// Tick, set pixel, rejected and unused requests leave the sequencer ready.
// Send reads pixel 0 from the store, then starts the frame; fill and clear first
// write every pixel below the pixel count, one store write per cycle, then send.
// After reset a clearing pass writes zeros to all MAX_LEDS store entries,
// one per cycle, with cmd_stall high; config writes are taken meanwhile.
// A result waiting on res_stall holds cmd_stall high until it is taken.
// ----------------------------------------------------------------------------
module rgb_led_strip_serial_driver #(
	parameter int MAX_LEDS        = 1024,
	parameter int BYTES_PER_PIXEL = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_stall,
	input  rgbled_pkg::cmd_t                      cmd,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output rgbled_pkg::res_t                      res,
	input  logic                                  cfg_write,
	input  logic [rgbled_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgbled_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rgbled_pkg::*;

	localparam int WORD_W = 8 * BYTES_PER_PIXEL;
	localparam int AW     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CW     = ($clog2(MAX_LEDS + 1) > LED_CNT_W) ?
	                        $clog2(MAX_LEDS + 1) : LED_CNT_W;
	localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_LEDS);
	localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_LEDS - 1);

	// configuration, stored at effective values
	timing_t       timing_q;
	logic [CW-1:0] led_eff_q;
	logic [CW-1:0] cnt_wr;

	assign cnt_wr = CW'(cfg_data[LED_CNT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_eff_q          <= CW'(1);
			timing_q.zero_high <= RST_ZERO_HIGH;
			timing_q.zero_low  <= RST_ZERO_LOW;
			timing_q.one_high  <= RST_ONE_HIGH;
			timing_q.one_low   <= RST_ONE_LOW;
			timing_q.gap       <= RST_GAP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LED_COUNT: begin
					if (cnt_wr == '0)          led_eff_q <= CW'(1);
					else if (cnt_wr > MAX_CNT) led_eff_q <= MAX_CNT;
					else                       led_eff_q <= cnt_wr;
				end
				REG_ZERO_HIGH: timing_q.zero_high <= (cfg_data[TIME_W-1:0] == '0) ?
				                                     TIME_W'(1) : cfg_data[TIME_W-1:0];
				REG_ZERO_LOW:  timing_q.zero_low  <= (cfg_data[TIME_W-1:0] == '0) ?
				                                     TIME_W'(1) : cfg_data[TIME_W-1:0];
				REG_ONE_HIGH:  timing_q.one_high  <= (cfg_data[TIME_W-1:0] == '0) ?
				                                     TIME_W'(1) : cfg_data[TIME_W-1:0];
				REG_ONE_LOW:   timing_q.one_low   <= (cfg_data[TIME_W-1:0] == '0) ?
				                                     TIME_W'(1) : cfg_data[TIME_W-1:0];
				REG_RESET_GAP: timing_q.gap       <= (cfg_data == '0) ? GAP_W'(1) : cfg_data;
				default: begin
				end
			endcase
		end
	end

	// request decode
	seq_state_t        state_q, state_d;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     fill_end_q;
	logic [WORD_W-1:0] fill_word_q;
	timing_t           start_timing_q;
	timing_t           wave_timing;
	logic              res_valid_q;
	res_t              res_q, res_d;

	phase_t            phase, phase_nxt;
	logic [CW-1:0]     send_pixel;
	logic [CW-1:0]     pix_ahead;
	logic              busy;
	logic              cmd_accept;
	logic              is_start, is_control;
	logic [CW-1:0]     idx_ext;
	logic              in_range;
	logic              set_wr;
	logic              start_cmd;
	logic [WORD_W-1:0] color_word;
	wave_cmd_t         wave_cmd;

	logic              ram_we;
	logic [CW-1:0]     ram_wsel;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	assign busy       = (phase != PH_IDLE);
	assign cmd_stall  = (state_q != SQ_READY) || (res_valid_q && res_stall);
	assign cmd_accept = cmd_valid && !cmd_stall;

	always_comb begin
		is_start   = 1'b0;
		is_control = 1'b0;
		case (cmd.func) inside
			FN_FILL, FN_CLEAR, FN_SEND: begin
				is_start   = 1'b1;
				is_control = 1'b1;
			end
			FN_SET:  is_control = 1'b1;
			default: begin
			end
		endcase
	end

	assign idx_ext    = CW'(cmd.pixel_index);
	assign in_range   = idx_ext < led_eff_q;
	assign set_wr     = cmd_accept && (cmd.func == FN_SET) && !busy && in_range;
	assign start_cmd  = cmd_accept && is_start && !busy;
	assign color_word = WORD_W'({cmd.green, cmd.red, cmd.blue}) << (WORD_W - 24);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_CLEAR;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_CLEAR || state_q == SQ_FILL) begin
				fill_q <= fill_q + CW'(1);
			end else begin
				fill_q <= '0;
			end
		end
	end

	// fill length and first high phase follow the registers as of the request
	always_ff @(posedge clk) begin
		if (start_cmd) begin
			fill_word_q    <= (cmd.func == FN_FILL) ? color_word : '0;
			fill_end_q     <= led_eff_q - CW'(1);
			start_timing_q <= timing_q;
		end
	end

	always_comb begin
		state_d        = state_q;
		ram_we         = 1'b0;
		ram_wsel       = fill_q;
		ram_wdata      = '0;
		wave_cmd.start = 1'b0;
		wave_cmd.tick  = cmd_accept && (cmd.func == FN_TICK);
		unique case (state_q)
			SQ_CLEAR: begin
				ram_we = 1'b1;
				if (fill_q == LAST_ADDR) state_d = SQ_READY;
			end
			SQ_READY: begin
				if (set_wr) begin
					ram_we    = 1'b1;
					ram_wsel  = idx_ext;
					ram_wdata = color_word;
				end
				if (start_cmd) begin
					state_d = (cmd.func == FN_SEND) ? SQ_LOAD : SQ_FILL;
				end
			end
			SQ_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = fill_word_q;
				if (fill_q == fill_end_q) state_d = SQ_LOAD;
			end
			SQ_LOAD:  state_d = SQ_START;
			SQ_START: begin
				wave_cmd.start = 1'b1;
				state_d        = SQ_READY;
			end
			default:  state_d = SQ_READY;
		endcase
	end

	assign wave_timing = (state_q == SQ_START) ? start_timing_q : timing_q;

	// during a frame the store reads one pixel ahead of the one going out
	assign pix_ahead = send_pixel + CW'(1);
	assign ram_waddr = ram_wsel[AW-1:0];
	assign ram_raddr = (state_q == SQ_LOAD) ? '0 : pix_ahead[AW-1:0];

	rgbled_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_LEDS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	rgbled_wave #(
		.WORD_W (WORD_W),
		.CW     (CW)
	) u_wave (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (wave_cmd),
		.timing     (wave_timing),
		.pix_limit  (led_eff_q),
		.start_word (ram_rdata),
		.next_word  (ram_rdata),
		.phase      (phase),
		.phase_nxt  (phase_nxt),
		.send_pixel (send_pixel)
	);

	// result register; a started frame shows as high from the request on
	always_comb begin
		res_d.status = ST_OK;
		if (is_control && busy) begin
			res_d.status = ST_BUSY;
		end else if (cmd.func == FN_SET && !in_range) begin
			res_d.status = ST_RANGE;
		end
		if (is_start && !busy) begin
			res_d.line_level = 1'b1;
			res_d.busy_res   = 1'b1;
		end else begin
			res_d.line_level = (phase_nxt == PH_HIGH);
			res_d.busy_res   = (phase_nxt != PH_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ rtl/core/rgbled_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbled_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rgbled_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/rgbled_wave.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbled_wave
// Bit-serial waveform engine: shifts each pixel word out MSB first and times
// the high, low and gap phases in tick items.
// ----------------------------------------------------------------------------
module rgbled_wave #(
	parameter int WORD_W = 24,
	parameter int CW     = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rgbled_pkg::wave_cmd_t cmd,
	input  rgbled_pkg::timing_t   timing,
	input  logic [CW-1:0]         pix_limit,
	input  logic [WORD_W-1:0]     start_word,
	input  logic [WORD_W-1:0]     next_word,
	output rgbled_pkg::phase_t    phase,
	output rgbled_pkg::phase_t    phase_nxt,
	output logic [CW-1:0]         send_pixel
);
	import rgbled_pkg::*;

	localparam int BP_W = $clog2(WORD_W);
	localparam logic [BP_W-1:0] LAST_BIT = BP_W'(WORD_W - 1);

	phase_t            phase_q, phase_d;
	logic [GAP_W-1:0]  tick_q, tick_d;
	logic [BP_W-1:0]   bit_q, bit_d;
	logic [CW-1:0]     pix_q, pix_d;
	logic [WORD_W-1:0] word_q, word_d;
	logic [WORD_W-1:0] shifted;
	logic [CW-1:0]     pix_inc;
	logic [GAP_W-1:0]  start_high, shift_high, next_high, cur_low;

	assign shifted = {word_q[WORD_W-2:0], 1'b0};
	assign pix_inc = pix_q + CW'(1);

	// high phase length follows the bit that is about to go out
	assign start_high = start_word[WORD_W-1] ? GAP_W'(timing.one_high) : GAP_W'(timing.zero_high);
	assign shift_high = shifted[WORD_W-1]    ? GAP_W'(timing.one_high) : GAP_W'(timing.zero_high);
	assign next_high  = next_word[WORD_W-1]  ? GAP_W'(timing.one_high) : GAP_W'(timing.zero_high);
	assign cur_low    = word_q[WORD_W-1]     ? GAP_W'(timing.one_low)  : GAP_W'(timing.zero_low);

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		pix_d   = pix_q;
		word_d  = word_q;
		if (cmd.start) begin
			phase_d = PH_HIGH;
			tick_d  = start_high;
			bit_d   = '0;
			pix_d   = '0;
			word_d  = start_word;
		end else if (cmd.tick && phase_q != PH_IDLE) begin
			if (tick_q > GAP_W'(1)) begin
				tick_d = tick_q - GAP_W'(1);
			end else begin
				unique case (phase_q)
					PH_HIGH: begin
						phase_d = PH_LOW;
						tick_d  = cur_low;
					end
					PH_LOW: begin
						word_d = shifted;
						if (bit_q == LAST_BIT) begin
							bit_d = '0;
							pix_d = pix_inc;
							if (pix_inc >= pix_limit) begin
								phase_d = PH_GAP;
								tick_d  = timing.gap;
							end else begin
								// next word was prefetched while this pixel went out
								word_d  = next_word;
								phase_d = PH_HIGH;
								tick_d  = next_high;
							end
						end else begin
							bit_d   = bit_q + BP_W'(1);
							phase_d = PH_HIGH;
							tick_d  = shift_high;
						end
					end
					PH_GAP: begin
						phase_d = PH_IDLE;
						tick_d  = '0;
						bit_d   = '0;
						pix_d   = '0;
					end
					PH_IDLE: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			pix_q   <= '0;
			word_q  <= '0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			pix_q   <= pix_d;
			word_q  <= word_d;
		end
	end

	assign phase      = phase_q;
	assign phase_nxt  = phase_d;
	assign send_pixel = pix_q;

endmodule

@@ rtl/core/rgbled_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbled_checker
// Port-level checks on the result channel of the LED strip driver.
// ----------------------------------------------------------------------------
module rgbled_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_stall,
	input rgbled_pkg::res_t res
);
	import rgbled_pkg::*;

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// line can only be high inside a frame
	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.line_level |-> res.busy_res)
		else $error("line high while idle");

	// a busy rejection leaves the frame running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_BUSY |-> res.busy_res)
		else $error("busy rejection while idle");

	// range errors only come from an idle block
	a_range_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_RANGE |-> !res.busy_res && !res.line_level)
		else $error("range error during a frame");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status == ST_OK || res.status == ST_RANGE || res.status == ST_BUSY)
		else $error("undefined status code");

endmodule

bind rgb_led_strip_serial_driver rgbled_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

@@ tb/sv/led_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_checker
// Watches the request, result and register ports of the LED strip driver.
// Keeps its own pixel store, register copy and waveform state, predicts the
// result of every accepted request and compares results in order.
// ----------------------------------------------------------------------------
module led_frame_checker
	import rgbled_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic                  cmd_stall,
	input  cmd_t                  cmd,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  res_t                  res,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    results_seen,
	output int                    frames_done,
	output int                    busy_rejects,
	output int                    range_errors,
	output logic                  frame_on
);

	localparam int WORD_W      = 24;
	localparam int STORE_DEPTH = 1024;

	logic [WORD_W-1:0]    pix_mem [STORE_DEPTH];
	logic [LED_CNT_W-1:0] cnt_reg;
	logic [TIME_W-1:0]    zh_reg, zl_reg, oh_reg, ol_reg;
	logic [GAP_W-1:0]     gap_reg;

	logic [LED_CNT_W-1:0] px_num;
	logic [4:0]           bit_num;
	phase_t               phase;
	logic [GAP_W-1:0]     ticks_left;
	logic [WORD_W-1:0]    shreg;

	res_t line_res_q[$];

	assign frame_on = (phase != PH_IDLE);

	function automatic int active_len();
		int n;
		n = cnt_reg;
		if (n < 1) n = 1;
		if (n > STORE_DEPTH) n = STORE_DEPTH;
		return n;
	endfunction

	function automatic logic [GAP_W-1:0] floor_one(input logic [GAP_W-1:0] v);
		return (v == '0) ? GAP_W'(1) : v;
	endfunction

	task automatic load_high();
		phase = PH_HIGH;
		ticks_left = floor_one(shreg[WORD_W-1] ? oh_reg : zh_reg);
	endtask

	// called on the last tick of a phase; the next phase starts on that tick
	task automatic next_phase();
		case (phase)
		PH_HIGH: begin
			phase = PH_LOW;
			ticks_left = floor_one(shreg[WORD_W-1] ? ol_reg : zl_reg);
		end
		PH_LOW: begin
			shreg = shreg << 1;
			bit_num = bit_num + 5'd1;
			if (bit_num == WORD_W) begin
				bit_num = '0;
				px_num = px_num + 11'd1;
				// count is read live, so a smaller count written mid-frame cuts it short
				if (px_num >= active_len()) begin
					phase = PH_GAP;
					ticks_left = floor_one(gap_reg);
				end else begin
					shreg = pix_mem[px_num];
					load_high();
				end
			end else begin
				load_high();
			end
		end
		default: begin
			phase = PH_IDLE;
			ticks_left = '0;
			px_num = '0;
			bit_num = '0;
			frames_done++;
		end
		endcase
	endtask

	task automatic predict_step(input cmd_t c, output res_t r);
		logic [STATUS_W-1:0] st;
		logic [WORD_W-1:0]   w;
		logic                busy;
		int                  n;
		int                  i;
		st = ST_OK;
		busy = (phase != PH_IDLE);
		case (c.func)
		FN_TICK: begin
			if (busy) begin
				if (ticks_left > 1) ticks_left = ticks_left - 1'b1;
				else next_phase();
			end
		end
		FN_SET, FN_FILL, FN_CLEAR, FN_SEND: begin
			if (busy) begin
				st = ST_BUSY;
				busy_rejects++;
			end else begin
				n = active_len();
				if (c.func == FN_SET) begin
					if (c.pixel_index < n) pix_mem[c.pixel_index] = {c.green, c.red, c.blue};
					else begin
						st = ST_RANGE;
						range_errors++;
					end
				end else begin
					if (c.func != FN_SEND) begin
						w = (c.func == FN_FILL) ? {c.green, c.red, c.blue} : '0;
						for (i = 0; i < n; i++) pix_mem[i] = w;
					end
					px_num = '0;
					bit_num = '0;
					shreg = pix_mem[0];
					load_high();
				end
			end
		end
		default: ;
		endcase
		r.line_level = (phase == PH_HIGH);
		r.busy_res = (phase != PH_IDLE);
		r.status = st;
	endtask

	task automatic report(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		int   i;
		if (!arst_n) begin
			for (i = 0; i < STORE_DEPTH; i++) pix_mem[i] = '0;
			cnt_reg = 11'd1;
			zh_reg = RST_ZERO_HIGH;
			zl_reg = RST_ZERO_LOW;
			oh_reg = RST_ONE_HIGH;
			ol_reg = RST_ONE_LOW;
			gap_reg = RST_GAP;
			px_num = '0;
			bit_num = '0;
			phase = PH_IDLE;
			ticks_left = '0;
			shreg = '0;
			line_res_q.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			frames_done = 0;
			busy_rejects = 0;
			range_errors = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
				REG_LED_COUNT: cnt_reg = cfg_data[LED_CNT_W-1:0];
				REG_ZERO_HIGH: zh_reg = cfg_data[TIME_W-1:0];
				REG_ZERO_LOW:  zl_reg = cfg_data[TIME_W-1:0];
				REG_ONE_HIGH:  oh_reg = cfg_data[TIME_W-1:0];
				REG_ONE_LOW:   ol_reg = cfg_data[TIME_W-1:0];
				REG_RESET_GAP: gap_reg = cfg_data;
				default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall) begin
				predict_step(cmd, got);
				line_res_q.push_back(got);
			end
			if (res_valid && !res_stall) begin
				results_seen++;
				if (line_res_q.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					want = line_res_q.pop_front();
					if (res.line_level !== want.line_level)
						report($sformatf("line_level got %b want %b", res.line_level,
							want.line_level));
					if (res.busy_res !== want.busy_res)
						report($sformatf("busy_res got %b want %b", res.busy_res,
							want.busy_res));
					if (res.status !== want.status)
						report($sformatf("status got %0d want %0d", res.status, want.status));
				end
			end
			pending = line_res_q.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the LED strip serial driver: directed requests for idle and
// busy behavior, register extremes and mid-frame count changes, then random
// set/fill/clear/send frames driven out by ticks, with random gaps on the
// request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
	import rgbled_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd6;
	localparam logic [FUNC_W-1:0] FN_UNUSED_C = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	cmd_t                  cmd = '0;
	logic                  res_stall = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  cmd_stall;
	logic                  res_valid;
	res_t                  res;

	int   fail_count, pending, results_seen, frames_done, busy_rejects, range_errors;
	logic frame_on;

	int items_sent = 0;
	int cur_count = 1;
	int rs_left = 0;
	bit tight = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rgb_led_strip_serial_driver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	led_frame_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.frames_done  (frames_done),
		.busy_rejects (busy_rejects),
		.range_errors (range_errors),
		.frame_on     (frame_on)
	);

	// result-side stalls in bursts: long clean stretches, short blips, rare long holds
	always @(posedge clk) begin
		int r;
		if (rs_left > 0) begin
			rs_left <= rs_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				res_stall <= 1'b0;
				rs_left <= $urandom_range(30, 150);
			end else if (r < 65) begin
				res_stall <= 1'b0;
				rs_left <= $urandom_range(0, 5);
			end else if (r < 95) begin
				res_stall <= 1'b1;
				rs_left <= $urandom_range(0, 3);
			end else begin
				res_stall <= 1'b1;
				rs_left <= $urandom_range(10, 40);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic cmd_t pix_cmd(input logic [FUNC_W-1:0] f, input int idx,
		input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
		input logic [COLOR_W-1:0] b);
		cmd_t c;
		c.func = f;
		c.pixel_index = IDX_W'(idx);
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	function automatic cmd_t rand_cmd(input logic [FUNC_W-1:0] f);
		return pix_cmd(f, $urandom_range(0, 1023), COLOR_W'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom));
	endfunction

	function automatic int strip_len();
		if (cur_count < 1) return 1;
		if (cur_count > 1024) return 1024;
		return cur_count;
	endfunction

	// valid stays high across back-to-back requests; only lowered for a gap
	task automatic put(input cmd_t c);
		int gap;
		gap = tight ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic put_ticks(input int n);
		repeat (n) put(rand_cmd(FN_TICK));
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic run_out();
		do begin
			put_ticks(48);
			drain();
		end while (frame_on);
	endtask

	// registers are only written with no request outstanding
	task automatic wr_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		drain();
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(input int cnt, input int zh, input int zl, input int oh,
		input int ol, input int gap);
		cur_count = cnt;
		wr_reg(REG_LED_COUNT, cnt);
		wr_reg(REG_ZERO_HIGH, zh);
		wr_reg(REG_ZERO_LOW, zl);
		wr_reg(REG_ONE_HIGH, oh);
		wr_reg(REG_ONE_LOW, ol);
		wr_reg(REG_RESET_GAP, gap);
	endtask

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r < 3) return $urandom_range(4, 8);
		if (r < 8) return $urandom_range(2, 3);
		return 1;
	endfunction

	function automatic int pick_tick();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return $urandom_range(1, 2);
		if (r < 9) return 0;
		return $urandom_range(3, 8);
	endfunction

	function automatic int pick_index();
		if ($urandom_range(0, 4) != 0) return $urandom_range(0, strip_len() - 1);
		return $urandom_range(0, 1023);
	endfunction

	// mostly a frame: a few pixel writes, a start, ticks with stray requests mixed in
	task automatic random_round();
		int sel;
		logic [FUNC_W-1:0] go;
		drain();
		tight = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 1) != 0)
			set_all(pick_count(), pick_tick(), pick_tick(), pick_tick(), pick_tick(),
				($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12));
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(5, 20)) put(rand_cmd(FUNC_W'($urandom_range(0, 7))));
		end else begin
			repeat ($urandom_range(0, 4)) put(pix_cmd(FN_SET, pick_index(), COLOR_W'($urandom),
				COLOR_W'($urandom), COLOR_W'($urandom)));
			case ($urandom_range(0, 2))
			0: go = FN_FILL;
			1: go = FN_CLEAR;
			default: go = FN_SEND;
			endcase
			put(rand_cmd(go));
			repeat ($urandom_range(10, 80)) begin
				sel = $urandom_range(0, 19);
				if (sel == 0) put(rand_cmd(FUNC_W'($urandom_range(1, 7))));
				else put(rand_cmd(FN_TICK));
			end
			if ($urandom_range(0, 4) == 0) begin
				drain();
				cur_count = pick_count();
				wr_reg(REG_LED_COUNT, cur_count);
			end
			run_out();
		end
		tight = 1'b0;
	endtask

	initial begin
		int rand_start;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// idle: ticks and unused codes do nothing
		put(rand_cmd(FN_TICK));
		put(rand_cmd(FN_UNUSED_A));
		put(rand_cmd(FN_UNUSED_B));
		put(rand_cmd(FN_UNUSED_C));
		put(pix_cmd(FN_SET, 0, 8'h0f, 8'ha5, 8'hff));
		put(pix_cmd(FN_SET, 1, 8'hff, 8'hff, 8'hff));
		put(pix_cmd(FN_SET, 1023, 8'h00, 8'h00, 8'h00));
		put(rand_cmd(FN_SEND));
		// set, fill, clear and send are refused while the frame runs; unused codes do nothing
		put(rand_cmd(FN_SET));
		put(rand_cmd(FN_FILL));
		put(rand_cmd(FN_CLEAR));
		put(rand_cmd(FN_SEND));
		put(rand_cmd(FN_UNUSED_C));
		// a few bits at the power-up timing, then the rest of the frame at speed
		put_ticks(40);
		drain();
		set_all(1, 1, 1, 1, 1, 4);
		run_out();

		// zero in any register behaves as one
		set_all(0, 0, 0, 0, 0, 0);
		put(pix_cmd(FN_SET, 0, 8'hff, 8'h00, 8'h5a));
		put(rand_cmd(FN_SEND));
		run_out();

		// count beyond the store: fill covers all 1024, then shorten mid-frame
		set_all(2047, 1, 1, 1, 1, 1);
		put(pix_cmd(FN_FILL, 0, 8'hc3, 8'h3c, 8'hff));
		put_ticks(120);
		drain();
		cur_count = 3;
		wr_reg(REG_LED_COUNT, cur_count);
		run_out();
		put(pix_cmd(FN_SET, 1023, 8'h12, 8'h34, 8'h56));
		cur_count = 1024;
		wr_reg(REG_LED_COUNT, cur_count);
		put(pix_cmd(FN_SET, 1023, 8'h12, 8'h34, 8'h56));
		put(rand_cmd(FN_CLEAR));
		put_ticks(60);
		drain();
		cur_count = 2;
		wr_reg(REG_LED_COUNT, cur_count);
		run_out();

		// longest high phase of a one bit; the gap register sits at its top value
		// and is lowered before the frame reaches the gap
		set_all(1, 1, 1, 255, 1, 65535);
		put(pix_cmd(FN_SET, 0, 8'h00, 8'h80, 8'h01));
		put(rand_cmd(FN_SEND));
		put_ticks(260);
		drain();
		wr_reg(REG_ONE_HIGH, 1);
		wr_reg(REG_RESET_GAP, 4);
		run_out();

		rand_start = items_sent;
		while (items_sent - rand_start < 550) random_round();

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests, checked %0d results over %0d frames.", items_sent,
			results_seen, frames_done);
		$display("Saw %0d busy refusals and %0d out-of-range pixel writes.", busy_rejects,
			range_errors);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/rgbled_pkg.sv
rtl/core/rgbled_ram.sv
rtl/core/rgbled_wave.sv
rtl/core/rgb_led_strip_serial_driver.sv
rtl/core/rgbled_checker.sv
tb/sv/led_frame_checker.sv
tb/sv/tb_top.sv
